// ===== sv/medf_pkg.sv =====
// Shared constants and codes for the message event deframer.
package medf_pkg;

    localparam int DataW  = 8;
    localparam int TimeW  = 32;
    localparam int DeltaW = 22;
    localparam int LenW   = 9;
    localparam int KindW  = 2;
    localparam int PhaseW = 3;

    localparam int InTdataW  = 8;
    localparam int OutTdataW = 80;
    localparam int OutTuserW = 3;

    localparam logic [DataW-1:0]  PING_CHANNEL = 8'h83;
    localparam int                BOOST_BIT    = 3;
    localparam logic [LenW-1:0]   BOOST_LEN    = 9'd64;
    localparam logic [LenW-1:0]   PING_SKIP    = 9'd8;
    localparam logic [1:0]        EXTRA_NONE   = 2'd3;

    localparam logic [PhaseW-1:0] PH_START   = 3'd0;
    localparam logic [PhaseW-1:0] PH_DELTA   = 3'd1;
    localparam logic [PhaseW-1:0] PH_PLAYER  = 3'd2;
    localparam logic [PhaseW-1:0] PH_CHANNEL = 3'd3;
    localparam logic [PhaseW-1:0] PH_LENGTH  = 3'd4;
    localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd5;
    localparam logic [PhaseW-1:0] PH_SKIP    = 3'd6;

    typedef enum logic [KindW-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_PING  = 2'd2,
        KIND_TRUNC = 2'd3
    } kind_t;

endpackage

// ===== sv/message_event_deframer_unit.sv =====
// Top level: chat event record deframer, one stream byte per word.
// Takes one stream byte per cycle while s_tready is high and gives at most one result word
// per byte, in the cycle after the byte is accepted. The record parser updates its state and
// loads the result register in the same cycle; the result register decouples the output, so
// a new byte is taken in any cycle in which the result register is empty or is being drained.
// The 32-bit timestamp adds set the cycle time. start_of_file (s_tuser) clears the timestamp
// and restarts at record start; s_tlast ends the stream and flags an unfinished record.
module message_event_deframer_unit
    import medf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [InTdataW-1:0]   s_tdata,   // data_byte[7:0]
    input  logic [0:0]            s_tuser,   // start_of_file[0]
    input  logic                  s_tlast,   // end_of_file
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutTdataW-1:0]  m_tdata,   // timestamp[31:0], player_index[39:32],
                                             // channel[47:40], length[56:48],
                                             // payload_byte[64:57], byte_index[73:65]
    output logic [OutTuserW-1:0]  m_tuser,   // kind[1:0], truncated[2]
    output logic                  m_tlast    // last
);

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [TimeW-1:0]  time_reg, time_next;
    logic [DeltaW-1:0] delta_reg, delta_next;
    logic [1:0]        extra_reg, extra_next;
    logic [DataW-1:0]  player_reg, player_next;
    logic [DataW-1:0]  channel_reg, channel_next;
    logic [LenW-1:0]   length_reg, length_next;
    logic [LenW-1:0]   left_reg, left_next;

    logic              valid_reg;
    logic [OutTdataW-1:0] data_reg, data_next;
    logic [OutTuserW-1:0] user_reg, user_next;
    logic              last_reg, last_next;
    logic              have_next;

    logic              accept;
    logic [DataW-1:0]  b;
    logic              sof;
    logic              eof;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !valid_reg || m_tready;
    assign b        = s_tdata[DataW-1:0];
    assign sof      = s_tuser[0];
    assign eof      = s_tlast;

    always_comb
    begin
        logic [PhaseW-1:0] ph;
        logic              have;
        kind_t             kind;
        logic [DataW-1:0]  pay;
        logic [LenW-1:0]   idx;
        logic              unfinished;
        logic              last_v;
        logic              trunc_v;

        ph           = phase_reg;
        time_next    = time_reg;
        delta_next   = delta_reg;
        extra_next   = extra_reg;
        player_next  = player_reg;
        channel_next = channel_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        have         = 1'b0;
        kind         = KIND_BYTE;
        pay          = '0;
        idx          = '0;
        last_v       = 1'b0;
        trunc_v      = 1'b0;

        if (sof)
        begin
            time_next = '0;
            ph        = PH_START;
        end

        phase_next = ph;
        unique case (ph)
            PH_START:
            begin
                player_next  = '0;
                channel_next = '0;
                length_next  = '0;
                left_next    = '0;
                delta_next   = {{(DeltaW-6){1'b0}}, b[7:2]};
                extra_next   = (b[1:0] == EXTRA_NONE) ? 2'd0 : b[1:0];
                if (extra_next == 2'd0)
                begin
                    time_next  = time_next + {{(TimeW-DeltaW){1'b0}}, delta_next};
                    phase_next = PH_PLAYER;
                end
                else
                begin
                    phase_next = PH_DELTA;
                end
            end
            PH_DELTA:
            begin
                delta_next = {delta_reg[DeltaW-9:0], b};
                extra_next = extra_reg - 2'd1;
                if (extra_next == 2'd0)
                begin
                    time_next  = time_next + {{(TimeW-DeltaW){1'b0}}, delta_next};
                    phase_next = PH_PLAYER;
                end
            end
            PH_PLAYER:
            begin
                player_next = b - 8'd1;
                phase_next  = PH_CHANNEL;
            end
            PH_CHANNEL:
            begin
                channel_next = b;
                if (b == PING_CHANNEL)
                begin
                    have       = 1'b1;
                    kind       = KIND_PING;
                    left_next  = PING_SKIP;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    phase_next = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                length_next = {1'b0, b} + (channel_reg[BOOST_BIT] ? BOOST_LEN : '0);
                left_next   = length_next;
                if (length_next == '0)
                begin
                    have       = 1'b1;
                    kind       = KIND_EMPTY;
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                have      = 1'b1;
                kind      = KIND_BYTE;
                pay       = b;
                idx       = length_reg - left_reg;
                left_next = left_reg - 9'd1;
                if (left_next == '0)
                    phase_next = PH_START;
            end
            default:
            begin
                left_next = left_reg - 9'd1;
                if (left_next == '0)
                    phase_next = PH_START;
            end
        endcase

        unfinished = (phase_next != PH_START);
        if (eof)
        begin
            phase_next = PH_START;
            last_v     = 1'b1;
            trunc_v    = unfinished;
            if (!have && unfinished)
            begin
                have = 1'b1;
                kind = KIND_TRUNC;
            end
        end
        else
        begin
            last_v = (kind != KIND_BYTE) || !unfinished;
        end

        have_next = have;
        last_next = last_v;
        user_next = {trunc_v, kind};
        data_next = {6'd0, idx, pay, length_next, channel_next, player_next, time_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            time_reg    <= '0;
            delta_reg   <= '0;
            extra_reg   <= '0;
            player_reg  <= '0;
            channel_reg <= '0;
            length_reg  <= '0;
            left_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                time_reg    <= time_next;
                delta_reg   <= delta_next;
                extra_reg   <= extra_next;
                player_reg  <= player_next;
                channel_reg <= channel_next;
                length_reg  <= length_next;
                left_reg    <= left_next;
                valid_reg   <= have_next;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && have_next)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 3'd7)
        else $error("parser phase out of range");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != '0 && left_reg <= length_reg)
        else $error("payload count outside record length");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> phase_reg == PH_START)
        else $error("parser not at record start after end of stream");

    a_player_delta_done: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PLAYER |-> extra_reg == 2'd0)
        else $error("delta bytes pending at player byte");

    a_trunc_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == KIND_TRUNC |-> m_tlast && m_tuser[2])
        else $error("truncated record word without last and truncated flags");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the chat event record deframer (stream in, result words out).
module tb_top
    import medf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        logic       eof;
        logic [1:0] mode;
        logic       drain;
        logic       hold;
    } stream_word_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] ts;
        logic [7:0]  player;
        logic [7:0]  chan;
        logic [8:0]  len;
        logic [7:0]  pay;
        logic [8:0]  idx;
        logic        last;
        logic        trunc;
    } chat_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InTdataW-1:0]  s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutTdataW-1:0] m_tdata;
    logic [OutTuserW-1:0] m_tuser;
    logic                 m_tlast;

    stream_word_t stream_words[$];
    chat_event_t  pending_events[$];
    logic [7:0]   rec_q[$];

    // deframer state as predicted
    logic [PhaseW-1:0] ph = PH_START;
    logic [31:0]       time_acc = '0;
    logic [21:0]       delta_acc = '0;
    logic [1:0]        extra_cnt = '0;
    logic [7:0]        cur_player = '0;
    logic [7:0]        cur_chan = '0;
    logic [8:0]        cur_len = '0;
    logic [8:0]        remain = '0;

    int          events_predicted = 0;
    int          events_seen = 0;
    int          words_accepted = 0;
    int          mismatches = 0;
    int          kind_seen[4] = '{0, 0, 0, 0};
    int          cycles = 0;
    int          hold_cnt = 0;
    logic [1:0]  cur_mode = 2'd0;
    logic        stall_req = 1'b0;
    logic        stall_seen = 1'b0;

    logic [1:0]  gen_mode = 2'd0;
    logic        gen_drain = 1'b0;
    logic        gen_hold = 1'b0;
    int          words_made = 0;

    message_event_deframer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    function automatic int idle_pct(logic [1:0] mode);
        return (mode == 2'd3) ? 31 : 62;
    endfunction

    function automatic void deframe_byte(logic [7:0] b, logic sof, logic eof);
        logic        have;
        logic        unfinished;
        kind_t       k;
        logic [7:0]  pay;
        logic [8:0]  idx;
        logic        last;
        logic        trunc;
        chat_event_t ev;
        have = 1'b0;
        k = KIND_BYTE;
        pay = '0;
        idx = '0;
        last = 1'b0;
        trunc = 1'b0;
        if (sof)
        begin
            time_acc = '0;
            ph = PH_START;
        end
        case (ph)
            PH_START:
            begin
                cur_player = '0;
                cur_chan = '0;
                cur_len = '0;
                remain = '0;
                delta_acc = {16'd0, b[7:2]};
                extra_cnt = b[1:0];
                if (extra_cnt == EXTRA_NONE)
                    extra_cnt = 2'd0;
                if (extra_cnt == 2'd0)
                begin
                    time_acc = time_acc + {10'd0, delta_acc};
                    ph = PH_PLAYER;
                end
                else
                    ph = PH_DELTA;
            end
            PH_DELTA:
            begin
                delta_acc = {delta_acc[13:0], b};
                extra_cnt = extra_cnt - 2'd1;
                if (extra_cnt == 2'd0)
                begin
                    time_acc = time_acc + {10'd0, delta_acc};
                    ph = PH_PLAYER;
                end
            end
            PH_PLAYER:
            begin
                cur_player = b - 8'd1;
                ph = PH_CHANNEL;
            end
            PH_CHANNEL:
            begin
                cur_chan = b;
                if (b == PING_CHANNEL)
                begin
                    have = 1'b1;
                    k = KIND_PING;
                    remain = PING_SKIP;
                    ph = PH_SKIP;
                end
                else
                    ph = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                cur_len = {1'b0, b} + (cur_chan[BOOST_BIT] ? BOOST_LEN : 9'd0);
                remain = cur_len;
                if (cur_len == 9'd0)
                begin
                    have = 1'b1;
                    k = KIND_EMPTY;
                    ph = PH_START;
                end
                else
                    ph = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                have = 1'b1;
                k = KIND_BYTE;
                pay = b;
                idx = cur_len - remain;
                remain = remain - 9'd1;
                if (remain == 9'd0)
                    ph = PH_START;
            end
            default:
            begin
                remain = remain - 9'd1;
                if (remain == 9'd0)
                    ph = PH_START;
            end
        endcase
        if (eof)
        begin
            unfinished = (ph != PH_START);
            ph = PH_START;
            if (have)
            begin
                last = 1'b1;
                trunc = unfinished;
            end
            else if (unfinished)
            begin
                have = 1'b1;
                k = KIND_TRUNC;
                last = 1'b1;
                trunc = 1'b1;
            end
        end
        else if (have)
            last = (k != KIND_BYTE) || (ph == PH_START);
        if (have)
        begin
            ev.kind = k;
            ev.ts = time_acc;
            ev.player = cur_player;
            ev.chan = cur_chan;
            ev.len = cur_len;
            ev.pay = pay;
            ev.idx = idx;
            ev.last = last;
            ev.trunc = trunc;
            pending_events.push_back(ev);
            events_predicted++;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void add_word(logic [7:0] b, logic sof, logic eof);
        stream_word_t w;
        w.data = b;
        w.sof = sof;
        w.eof = eof;
        w.mode = gen_mode;
        w.drain = gen_drain;
        w.hold = gen_hold;
        gen_drain = 1'b0;
        gen_hold = 1'b0;
        stream_words.push_back(w);
        words_made++;
    endfunction

    function automatic void append_record(bit big);
        logic [1:0] code;
        logic [5:0] lead;
        logic [7:0] chan;
        logic [7:0] lenb;
        int         n_pay;
        code = 2'($urandom_range(3));
        lead = 6'($urandom);
        rec_q.push_back({lead, code});
        if (code == 2'd1 || code == 2'd2)
            rec_q.push_back(8'($urandom));
        if (code == 2'd2)
            rec_q.push_back(8'($urandom));
        rec_q.push_back(8'($urandom));
        if (!big && $urandom_range(99) < 20)
            chan = PING_CHANNEL;
        else
            chan = 8'($urandom);
        if (big)
            chan[BOOST_BIT] = 1'b1;
        else if (chan != PING_CHANNEL && $urandom_range(99) < 85)
            chan[BOOST_BIT] = 1'b0;
        rec_q.push_back(chan);
        if (chan == PING_CHANNEL)
        begin
            for (int i = 0; i < PING_SKIP; i++)
                rec_q.push_back(8'($urandom));
        end
        else
        begin
            if (big)
                lenb = 8'hFF;
            else if ($urandom_range(99) < 15)
                lenb = 8'd0;
            else
                lenb = 8'($urandom_range(1, 6));
            rec_q.push_back(lenb);
            n_pay = lenb + (chan[BOOST_BIT] ? 64 : 0);
            for (int i = 0; i < n_pay; i++)
                rec_q.push_back(8'($urandom));
        end
    endfunction

    // choice: below 10 cut without end mark, below 20 cut with end mark, 90 and up no end mark
    function automatic void add_file(bit force_big);
        int   n_rec;
        int   cut;
        int   choice;
        logic sof;
        logic eof_end;
        rec_q.delete();
        n_rec = $urandom_range(1, 4);
        for (int i = 0; i < n_rec; i++)
            append_record((force_big && i == 0) || $urandom_range(99) < 2);
        choice = $urandom_range(99);
        cut = rec_q.size();
        if (choice < 20 && rec_q.size() > 1)
            cut = $urandom_range(1, rec_q.size() - 1);
        eof_end = !(choice < 10 || choice >= 90);
        sof = $urandom_range(99) < 70;
        for (int i = 0; i < cut; i++)
            add_word(rec_q[i], sof && i == 0, eof_end && i == cut - 1);
    endfunction

    always @(posedge clk)
    begin
        logic         sent_now;
        stream_word_t w;
        if (rst_n)
        begin
            sent_now = s_tvalid && s_tready;
            if (sent_now)
            begin
                deframe_byte(s_tdata, s_tuser[0], s_tlast);
                words_accepted++;
            end
            if (!s_tvalid || sent_now)
            begin
                if (stream_words.size() > 0
                    && !(stream_words[0].drain && events_seen != events_predicted)
                    && !(stream_words[0].mode[0]
                         && $urandom_range(99) < idle_pct(stream_words[0].mode)))
                begin
                    w = stream_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= w.data;
                    s_tuser <= w.sof;
                    s_tlast <= w.eof;
                    cur_mode <= w.mode;
                    if (w.hold)
                        stall_req <= ~stall_req;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req != stall_seen)
            begin
                stall_seen <= stall_req;
                hold_cnt <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(cur_mode[1] && $urandom_range(99) < idle_pct(cur_mode));
        end
    end

    always @(posedge clk)
    begin
        chat_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen <= events_seen + 1;
            kind_seen[m_tuser[1:0]]++;
            if (pending_events.size() == 0)
            begin
                $error("result word 0x%0h arrived with none expected", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser[1:0]));
                check_field("timestamp", want.ts, m_tdata[31:0]);
                check_field("player_index", 32'(want.player), 32'(m_tdata[39:32]));
                check_field("channel", 32'(want.chan), 32'(m_tdata[47:40]));
                check_field("length", 32'(want.len), 32'(m_tdata[56:48]));
                check_field("payload_byte", 32'(want.pay), 32'(m_tdata[64:57]));
                check_field("byte_index", 32'(want.idx), 32'(m_tdata[73:65]));
                check_field("last", 32'(want.last), 32'(m_tlast));
                check_field("truncated", 32'(want.trunc), 32'(m_tuser[2]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, events_predicted - events_seen);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int  dir_count;
        int  phase_no;
        bit  hold_done;
        bit  big_done;
        hold_done = 0;
        big_done = 0;

        // ping with extreme lead and player wrap, then skip
        add_word(8'hFC, 1'b1, 1'b0);
        add_word(8'h00, 1'b0, 1'b0);
        add_word(PING_CHANNEL, 1'b0, 1'b0);
        for (int i = 0; i < PING_SKIP; i++)
            add_word((i % 2) ? 8'h00 : 8'hFF, 1'b0, 1'b0);
        // code three with empty message
        add_word(8'hFF, 1'b0, 1'b0);
        add_word(8'h01, 1'b0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0);
        // largest two-byte delta, ping cut short by end of stream
        add_word(8'hFE, 1'b1, 1'b0);
        add_word(8'hFF, 1'b0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0);
        add_word(PING_CHANNEL, 1'b0, 1'b1);
        // end on the last delta byte, before the player byte
        add_word(8'h01, 1'b0, 1'b0);
        add_word(8'h55, 1'b0, 1'b1);
        // end on a payload byte that is not the final one
        add_word(8'h00, 1'b0, 1'b0);
        add_word(8'h01, 1'b0, 1'b0);
        add_word(8'h00, 1'b0, 1'b0);
        add_word(8'h02, 1'b0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b1);
        dir_count = words_made;

        gen_drain = 1'b1;
        while (words_made < dir_count + RANDOM_WORDS)
        begin
            phase_no = (words_made - dir_count) * 4 / RANDOM_WORDS;
            if (phase_no > 3)
                phase_no = 3;
            if (phase_no != gen_mode)
            begin
                gen_mode = 2'(phase_no);
                gen_drain = 1'b1;
            end
            if (!hold_done && phase_no == 0 && words_made - dir_count > 200)
            begin
                gen_hold = 1'b1;
                hold_done = 1;
            end
            if ($urandom_range(99) < 8)
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    add_word(8'($urandom), $urandom_range(99) < 20, $urandom_range(99) < 20);
            end
            else
            begin
                add_file(!big_done);
                big_done = 1;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_words.size() != 0 || s_tvalid)
            @(posedge clk);
        while (events_seen < events_predicted)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_events.size());
            mismatches++;
        end

        $display("Fed %0d stream words in four idle/stall phases with a %0d-cycle output hold-off",
                 words_accepted, HOLD_CYCLES);
        $display("Checked %0d results: %0d bytes, %0d empty, %0d pings, %0d truncated records",
                 events_seen, kind_seen[KIND_BYTE], kind_seen[KIND_EMPTY],
                 kind_seen[KIND_PING], kind_seen[KIND_TRUNC]);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
